// ----- rtl/encoder_speed_estimator_top_macros.svh -----
// ----------------------------------------------------------------------------
// Encoder speed estimator assertion macros
// Concurrent assertion shorthands used by the top level; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_ESTIMATOR_TOP_MACROS_SVH
`define ENCODER_SPEED_ESTIMATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/encspd_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder speed estimator package
// Shared widths, constants, register codes and interface types.
// ----------------------------------------------------------------------------
package encspd_pkg;

    localparam int CHANNELS        = 4;
    localparam int CH_IDX_W        = $clog2(CHANNELS);
    localparam int IN_W            = 2 * CHANNELS;
    localparam int SPEED_W         = 24;
    localparam int OUT_W           = CHANNELS * SPEED_W;
    localparam int WIN_W           = 16;
    localparam int SCALE_W         = 16;
    localparam int K_W             = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;

    localparam logic [WIN_W-1:0]    WINDOW_RST = 16'd50;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd3168;
    localparam logic [K_W-1:0]      K_RST      = 8'd77;
    localparam logic [CHANNELS-1:0] INVERT_RST = 4'd6;

    localparam logic signed [PROD_W-1:0] FRESH_HI =
        {{(PROD_W-MUL_A_W+1){1'b0}}, {(MUL_A_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] FRESH_LO =
        {{(PROD_W-MUL_A_W+1){1'b1}}, {(MUL_A_W-1){1'b0}}};

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 52'sd128;
    localparam logic signed [ACC_W-1:0] SPEED_HI =
        {{(ACC_W-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SPEED_LO =
        {{(ACC_W-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_K      = 2'd2,
        CFG_INVERT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [WIN_W-1:0]    window_ticks;
        logic [SCALE_W-1:0]  speed_scale;
        logic [K_W-1:0]      filter_k;
        logic [CHANNELS-1:0] invert_mask;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic load;
    } blend_status_t;

endpackage

// ----- rtl/encspd_counter.sv -----
// ----------------------------------------------------------------------------
// Encoder edge and window counter
// Counts falling edges of A per channel and marks the tick that ends a window.
// ----------------------------------------------------------------------------
module encspd_counter
    import encspd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [CHANNELS-1:0]           enc_a,
    input  logic [CHANNELS-1:0]           enc_b,
    input  logic                          clear,
    input  logic [WIN_W-1:0]              window_ticks,
    output logic signed [COUNT_WIDTH-1:0] count [CHANNELS],
    output logic                          win_end
);

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic [CHANNELS-1:0]           prev_a_reg;
    logic [WIN_W-1:0]              tick_reg;
    logic [WIN_W-1:0]              tick_next;
    logic signed [COUNT_WIDTH-1:0] count_reg  [CHANNELS];
    logic signed [COUNT_WIDTH-1:0] count_next [CHANNELS];
    logic [CHANNELS-1:0]           falling;
    logic [WIN_W-1:0]              win_eff;
    logic [WIN_W:0]                tick_inc;

    always_comb begin
        falling  = prev_a_reg & ~enc_a;
        win_eff  = (window_ticks == '0) ? WIN_W'(1) : window_ticks;
        tick_inc = {1'b0, tick_reg} + (WIN_W+1)'(1);
        win_end  = accept && (tick_inc >= {1'b0, win_eff});
        tick_next = win_end ? '0 : tick_inc[WIN_W-1:0];
        for (int i = 0; i < CHANNELS; i++) begin
            count_next[i] = count_reg[i];
            if (clear) begin
                count_next[i] = '0;
            end else if (accept && falling[i]) begin
                if (enc_b[i]) begin
                    if (count_reg[i] != CNT_MAX) begin
                        count_next[i] = count_reg[i] + COUNT_WIDTH'(1);
                    end
                end else if (count_reg[i] != CNT_MIN) begin
                    count_next[i] = count_reg[i] - COUNT_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_a_reg <= '0;
            tick_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            count_reg <= count_next;
            if (accept) begin
                prev_a_reg <= enc_a;
                tick_reg   <= tick_next;
            end
        end
    end

    assign count = count_reg;

endmodule

// ----- rtl/encspd_mul.sv -----
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One registered 34 by 17 bit signed multiply, reused for every product.
// ----------------------------------------------------------------------------
module encspd_mul
    import encspd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/encspd_blend.sv -----
// ----------------------------------------------------------------------------
// Speed blend sequencer
// Walks the channels through scale, clamp, filter mix and rounding on the
// shared multiplier and keeps the filtered speeds.
// ----------------------------------------------------------------------------
module encspd_blend
    import encspd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  cfg_t                          cfg,
    input  logic signed [COUNT_WIDTH-1:0] count [CHANNELS],
    input  logic                          out_free,
    output blend_status_t                 status,
    output logic signed [SPEED_W-1:0]     speed [CHANNELS]
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCALE  = 7'b0000010,
        ST_CLAMP  = 7'b0000100,
        ST_MIXNEW = 7'b0001000,
        ST_MIXOLD = 7'b0010000,
        ST_ROUND  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } blend_state_t;

    blend_state_t              state_reg;
    blend_state_t              state_next;
    logic [CH_IDX_W-1:0]       ch_reg;
    logic [CH_IDX_W-1:0]       ch_next;
    logic signed [MUL_A_W-1:0] fresh_reg;
    logic signed [MUL_A_W-1:0] fresh_next;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [SPEED_W-1:0] filt_reg [CHANNELS];
    logic signed [SPEED_W-1:0] speed_next;

    logic                      mul_en;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_sgn;
    logic signed [ACC_W-1:0]   round_sum;
    logic signed [ACC_W-1:0]   round_shr;
    logic [K_W:0]              k_comp;
    logic                      last_ch;

    encspd_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb begin
        k_comp  = (K_W+1)'(256) - {1'b0, cfg.filter_k};
        last_ch = (ch_reg == CH_IDX_W'(CHANNELS - 1));
        mul_en  = 1'b0;
        op_a    = fresh_reg;
        op_b    = MUL_B_W'(k_comp);
        case (state_reg)
            ST_SCALE: begin
                mul_en = 1'b1;
                op_a   = MUL_A_W'(count[ch_reg]);
                op_b   = MUL_B_W'(cfg.speed_scale);
            end
            ST_MIXNEW: begin
                mul_en = 1'b1;
            end
            ST_MIXOLD: begin
                mul_en = 1'b1;
                op_a   = MUL_A_W'(filt_reg[ch_reg]);
                op_b   = MUL_B_W'(cfg.filter_k);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        prod_sgn = cfg.invert_mask[ch_reg] ? -prod : prod;
        if (prod_sgn > FRESH_HI) begin
            fresh_next = FRESH_HI[MUL_A_W-1:0];
        end else if (prod_sgn < FRESH_LO) begin
            fresh_next = FRESH_LO[MUL_A_W-1:0];
        end else begin
            fresh_next = prod_sgn[MUL_A_W-1:0];
        end
    end

    always_comb begin
        round_sum = ACC_W'(acc_reg) + ACC_W'(prod) + ROUND_BIAS;
        round_shr = round_sum >>> 8;
        if (round_shr > SPEED_HI) begin
            speed_next = SPEED_HI[SPEED_W-1:0];
        end else if (round_shr < SPEED_LO) begin
            speed_next = SPEED_LO[SPEED_W-1:0];
        end else begin
            speed_next = round_shr[SPEED_W-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        status.idle = (state_reg == ST_IDLE);
        status.load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_SCALE;
                    ch_next    = '0;
                end
            end
            ST_SCALE:  state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_MIXNEW;
            ST_MIXNEW: state_next = ST_MIXOLD;
            ST_MIXOLD: state_next = ST_ROUND;
            ST_ROUND: begin
                if (last_ch) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCALE;
                    ch_next    = ch_reg + CH_IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    status.load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                filt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            if (state_reg == ST_ROUND) begin
                filt_reg[ch_reg] <= speed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLAMP) begin
            fresh_reg <= fresh_next;
        end
        if (state_reg == ST_MIXOLD) begin
            acc_reg <= prod;
        end
    end

    assign speed = filt_reg;

endmodule

// ----- rtl/encoder_speed_estimator_top.sv -----
// ----------------------------------------------------------------------------
// Encoder speed estimator top level
// A tick that does not end a window leaves the block ready on the next cycle.
// A window-ending tick takes each channel through scale, clamp, filter mix and
// rounding on the shared multiplier; the result word loads once the output is
// free, when the block is ready again. Synchronous active-low reset restores
// the register defaults and clears counts, tick counter and filtered speeds.
// ----------------------------------------------------------------------------
`include "encoder_speed_estimator_top_macros.svh"

module encoder_speed_estimator_top
    import encspd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,      // enc_a, enc_b
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,      // speed_ch0, speed_ch1, speed_ch2, speed_ch3
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t                          cfg_reg;
    logic                          m_tvalid_reg;
    logic [OUT_W-1:0]              m_tdata_reg;
    logic                          accept;
    logic                          win_end;
    logic                          out_free;
    blend_status_t                 status;
    logic signed [COUNT_WIDTH-1:0] count [CHANNELS];
    logic signed [SPEED_W-1:0]     speed [CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_ticks <= WINDOW_RST;
            cfg_reg.speed_scale  <= SCALE_RST;
            cfg_reg.filter_k     <= K_RST;
            cfg_reg.invert_mask  <= INVERT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_wr_index))
                CFG_WINDOW: cfg_reg.window_ticks <= cfg_wr_data[WIN_W-1:0];
                CFG_SCALE:  cfg_reg.speed_scale  <= cfg_wr_data[SCALE_W-1:0];
                CFG_K:      cfg_reg.filter_k     <= cfg_wr_data[K_W-1:0];
                CFG_INVERT: cfg_reg.invert_mask  <= cfg_wr_data[CHANNELS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = status.idle;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    encspd_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .enc_a        (s_tdata[CHANNELS-1:0]),
        .enc_b        (s_tdata[IN_W-1:CHANNELS]),
        .clear        (status.load),
        .window_ticks (cfg_reg.window_ticks),
        .count        (count),
        .win_end      (win_end)
    );

    encspd_blend #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_blend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (win_end),
        .cfg      (cfg_reg),
        .count    (count),
        .out_free (out_free),
        .status   (status),
        .speed    (speed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (status.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (status.load) begin
            for (int i = 0; i < CHANNELS; i++) begin
                m_tdata_reg[i*SPEED_W +: SPEED_W] <= speed[i];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_NEXT(a_busy_after_window, aclk, aresetn, accept && win_end, !s_tready)
    `ASSERT_NEXT(a_ready_after_tick, aclk, aresetn, accept && !win_end, s_tready)
    `ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, status.load, m_tvalid)
    `ASSERT_IMPLIES(a_no_load_when_ready, aclk, aresetn, status.load, !s_tready)

endmodule
